// ===== design/acsp_pkg.sv =====
// Shared types, codes and helper functions for the animation clip stream parser.
`timescale 1ns / 1ps

package acsp_pkg;

  // Parse phases, one-hot.
  typedef enum logic [7:0] {
    PH_VERSION = 8'b0000_0001,
    PH_FCOUNT  = 8'b0000_0010,
    PH_SKIP    = 8'b0000_0100,
    PH_BCOUNT  = 8'b0000_1000,
    PH_CX      = 8'b0001_0000,
    PH_CY      = 8'b0010_0000,
    PH_CZ      = 8'b0100_0000,
    PH_IDLE    = 8'b1000_0000
  } phase_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_KEYFRAME    = 3'd0,
    ST_EMPTY_FRAME = 3'd1,
    ST_EMPTY_CLIP  = 3'd2,
    ST_UNKNOWN_VER = 3'd3,
    ST_TRUNCATED   = 3'd4
  } status_t;

  localparam logic [7:0] VERSION_FLOAT = 8'd0;
  localparam logic [7:0] VERSION_FIXED = 8'd1;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_buffer;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        is_float;
    logic [31:0] frame_index;
    logic [31:0] bone_index;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic        last_in_frame;
    logic        last_in_clip;
  } out_beat_t;

  typedef struct packed {
    phase_t      phase;
    logic        clip_version;   // 1: fixed-point clip, 0: float clip
    logic [31:0] frames_total;
    logic [31:0] frames_done;
    logic [31:0] bones_total;
    logic [31:0] bones_done;
    logic [1:0]  byte_in_field;
    logic [31:0] field_assembly;
    logic [31:0] held_x;
    logic [31:0] held_y;
  } parse_state_t;

  // Format one coordinate: fixed clips sign-extend 16 bits, float clips pass raw bits.
  // Negate flips the float sign bit or takes the two's complement of the fixed value.
  function automatic logic [31:0] coord_fmt(input logic [31:0] v, input logic fixed,
                                            input logic negate);
    logic [31:0] s;
    s = {{16{v[15]}}, v[15:0]};
    if (!fixed) begin
      coord_fmt = negate ? {~v[31], v[30:0]} : v;
    end else begin
      coord_fmt = negate ? (32'd0 - s) : s;
    end
  endfunction

endpackage

// ===== design/acsp_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat.
`timescale 1ns / 1ps

interface acsp_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/acsp_step.sv =====
// Next-state and result logic for one accepted byte.
`timescale 1ns / 1ps

module acsp_step (
  input  acsp_pkg::parse_state_t st,
  input  acsp_pkg::in_beat_t     beat,
  output acsp_pkg::parse_state_t st_next,
  output acsp_pkg::out_beat_t    res,
  output logic                   res_valid
);

  logic [31:0]       asm_new;
  logic [2:0]        field_len;
  logic              field_done;
  logic              bad_version;
  logic [31:0]       fd_inc;
  logic [31:0]       bd_inc;
  logic              frame_last;
  logic              bone_last;
  acsp_pkg::phase_t  frame_start;

  // Drop the byte into its lane of the field being assembled.
  always_comb begin
    asm_new = st.field_assembly;
    case (st.byte_in_field)
      2'd0:    asm_new[7:0]   = st.field_assembly[7:0]   | beat.byte_value;
      2'd1:    asm_new[15:8]  = st.field_assembly[15:8]  | beat.byte_value;
      2'd2:    asm_new[23:16] = st.field_assembly[23:16] | beat.byte_value;
      2'd3:    asm_new[31:24] = st.field_assembly[31:24] | beat.byte_value;
      default: asm_new = st.field_assembly;
    endcase
  end

  always_comb begin
    if (st.phase == acsp_pkg::PH_SKIP) begin
      field_len = 3'd1;
    end else if (st.clip_version) begin
      field_len = (st.phase == acsp_pkg::PH_FCOUNT) ? 3'd1 : 3'd2;
    end else begin
      field_len = 3'd4;
    end
  end

  assign field_done  = ({1'b0, st.byte_in_field} + 3'd1) >= field_len;
  assign bad_version = (st.phase == acsp_pkg::PH_VERSION) &&
                       !(beat.byte_value inside {acsp_pkg::VERSION_FLOAT,
                                                 acsp_pkg::VERSION_FIXED});
  assign fd_inc      = st.frames_done + 32'd1;
  assign bd_inc      = st.bones_done + 32'd1;
  assign frame_last  = fd_inc == st.frames_total;
  assign bone_last   = bd_inc == st.bones_total;
  assign frame_start = st.clip_version ? acsp_pkg::PH_BCOUNT : acsp_pkg::PH_SKIP;

  always_comb begin
    st_next   = st;
    res       = '0;
    res_valid = 1'b0;
    case (st.phase)
      acsp_pkg::PH_VERSION: begin
        st_next.frames_total   = '0;
        st_next.frames_done    = '0;
        st_next.bones_total    = '0;
        st_next.bones_done     = '0;
        st_next.byte_in_field  = '0;
        st_next.field_assembly = '0;
        if (bad_version) begin
          st_next.clip_version = 1'b0;
          st_next.phase        = acsp_pkg::PH_IDLE;
          res.status           = acsp_pkg::ST_UNKNOWN_VER;
          res_valid            = 1'b1;
        end else begin
          st_next.clip_version = beat.byte_value[0];
          st_next.phase        = acsp_pkg::PH_FCOUNT;
        end
      end
      acsp_pkg::PH_IDLE: begin
        st_next = st;
      end
      default: begin
        if (!field_done) begin
          st_next.field_assembly = asm_new;
          st_next.byte_in_field  = st.byte_in_field + 2'd1;
        end else begin
          st_next.field_assembly = '0;
          st_next.byte_in_field  = '0;
          res.is_float           = !st.clip_version;
          case (st.phase)
            acsp_pkg::PH_FCOUNT: begin
              st_next.frames_total = asm_new;
              st_next.frames_done  = '0;
              if (asm_new == 32'd0) begin
                st_next.phase    = acsp_pkg::PH_IDLE;
                res.status       = acsp_pkg::ST_EMPTY_CLIP;
                res.last_in_clip = 1'b1;
                res_valid        = 1'b1;
              end else begin
                st_next.phase = frame_start;
              end
            end
            acsp_pkg::PH_SKIP: begin
              st_next.phase = acsp_pkg::PH_BCOUNT;
            end
            acsp_pkg::PH_BCOUNT: begin
              st_next.bones_total = asm_new;
              st_next.bones_done  = '0;
              if (asm_new == 32'd0) begin
                st_next.frames_done = fd_inc;
                st_next.bones_total = '0;
                st_next.phase       = frame_last ? acsp_pkg::PH_IDLE : frame_start;
                res.status          = acsp_pkg::ST_EMPTY_FRAME;
                res.frame_index     = st.frames_done;
                res.last_in_frame   = 1'b1;
                res.last_in_clip    = frame_last;
                res_valid           = 1'b1;
              end else begin
                st_next.phase = acsp_pkg::PH_CX;
              end
            end
            acsp_pkg::PH_CX: begin
              st_next.held_x = acsp_pkg::coord_fmt(asm_new, st.clip_version, 1'b0);
              st_next.phase  = acsp_pkg::PH_CY;
            end
            acsp_pkg::PH_CY: begin
              st_next.held_y = acsp_pkg::coord_fmt(asm_new, st.clip_version, 1'b1);
              st_next.phase  = acsp_pkg::PH_CZ;
            end
            acsp_pkg::PH_CZ: begin
              res.status      = acsp_pkg::ST_KEYFRAME;
              res.frame_index = st.frames_done;
              res.bone_index  = st.bones_done;
              res.coord_x     = st.held_x;
              res.coord_y     = st.held_y;
              res.coord_z     = acsp_pkg::coord_fmt(asm_new, st.clip_version, 1'b0);
              res_valid       = 1'b1;
              if (bone_last) begin
                st_next.frames_done = fd_inc;
                st_next.bones_done  = '0;
                st_next.bones_total = '0;
                st_next.phase       = frame_last ? acsp_pkg::PH_IDLE : frame_start;
                res.last_in_frame   = 1'b1;
                res.last_in_clip    = frame_last;
              end else begin
                st_next.bones_done = bd_inc;
                st_next.phase      = acsp_pkg::PH_CX;
              end
            end
            default: begin
              st_next.phase = st.phase;
            end
          endcase
        end
      end
    endcase

    // End of buffer: report an unfinished clip, then rearm for the version byte.
    if (beat.end_of_buffer) begin
      if ((st_next.phase != acsp_pkg::PH_IDLE) && !bad_version) begin
        res             = '0;
        res.status      = acsp_pkg::ST_TRUNCATED;
        res.is_float    = !st_next.clip_version;
        res.frame_index = st_next.frames_done;
        res.bone_index  = st_next.bones_done;
        res_valid       = 1'b1;
      end
      st_next.phase          = acsp_pkg::PH_VERSION;
      st_next.byte_in_field  = '0;
      st_next.field_assembly = '0;
    end
  end

endmodule

// ===== design/animation_clip_stream_parser.sv =====
// Top level of the animation clip stream parser: parse state, result register, handshakes.
`timescale 1ns / 1ps

// Animation clip stream parser.
// bytes (sink): one clip byte per beat, with end_of_buffer on the last byte of a buffer;
//   the beat after it starts a new clip with its version byte.
// results (source): at most one beat per input byte: a keyframe per completed bone
//   (x, y, z; y negated), or an empty frame, empty clip, unknown version or truncation.
// A result appears on results in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle unless results stall. Every byte is handled by one pass
//   through the step logic between the parse state registers and the result register.
// Stall: the result register holds while results.ready is low; bytes.ready stays high
//   as long as that register is empty or is being drained in the same cycle, so a
//   stalled receiver backs up the byte stream after one held beat.
// Reset (rst, synchronous, active high): parse state returns to waiting for a version
//   byte, all counters clear and the result register is emptied.
// Bytes after a finished or failed clip give no result until end_of_buffer.
module animation_clip_stream_parser (
  input logic                  clk,
  input logic                  rst,
  acsp_stream_if.sink          bytes,
  acsp_stream_if.source        results
);

  acsp_pkg::parse_state_t st;
  acsp_pkg::parse_state_t st_next;
  acsp_pkg::out_beat_t    res;
  logic                   res_valid;
  logic                   out_valid;
  acsp_pkg::out_beat_t    out_data;
  logic                   accept;

  // Take a byte whenever the result register is free or drains this cycle.
  assign bytes.ready = !out_valid || results.ready;
  assign accept      = bytes.valid && bytes.ready;

  acsp_step u_step (
    .st        (st),
    .beat      (bytes.data),
    .st_next   (st_next),
    .res       (res),
    .res_valid (res_valid)
  );

  // Parse state: advance on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: acsp_pkg::PH_VERSION, default: '0};
    end else if (accept) begin
      st <= st_next;
    end
  end

  // Result register: load on a byte that yields a result, clear when drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_data <= res;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_data;

`ifndef NO_ASSERTIONS
  // A byte flagged end_of_buffer always rearms the parser for a version byte.
  a_eob_rearm: assert property (@(posedge clk) disable iff (rst)
    accept && bytes.data.end_of_buffer |=> st.phase == acsp_pkg::PH_VERSION)
    else $error("parser not rearmed after end of buffer");

  // Bytes taken after a clip is finished produce no result.
  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    accept && (st.phase == acsp_pkg::PH_IDLE) |=> !results.valid)
    else $error("result produced while idle");

  // While bone coordinates are expected, the bone count has not been reached.
  a_bone_bound: assert property (@(posedge clk) disable iff (rst)
    (st.phase == acsp_pkg::PH_CX) || (st.phase == acsp_pkg::PH_CY) ||
    (st.phase == acsp_pkg::PH_CZ) |-> st.bones_done < st.bones_total)
    else $error("bone counter past bone count");

  // A truncation never claims to end a frame or a clip.
  a_trunc_flags: assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.data.status == acsp_pkg::ST_TRUNCATED) |->
      !results.data.last_in_frame && !results.data.last_in_clip)
    else $error("truncation result carries end flags");
`endif

endmodule
